>>> design/decimal_to_seven_segment_formatter_assert.svh
// Assertion macros for the decimal to seven-segment formatter, used by its output serialiser.
`ifndef DECIMAL_TO_SEVEN_SEGMENT_FORMATTER_ASSERT_SVH
`define DECIMAL_TO_SEVEN_SEGMENT_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is active.
`define DSF_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, evaluated at every clock edge, reset included.
`define DSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSF_ASSERT_RST(lbl, prop, msg)
`define DSF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> design/dsf_pkg.sv
// Types, constants and helper functions for the decimal to seven-segment formatter.
package dsf_pkg;

    localparam int BIN_W      = 20;
    localparam int NUM_DIGITS = 6;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int DD_W       = BCD_W + BIN_W;
    localparam int STEPS_PER_STAGE = 5;

    // Shift register of the binary to BCD conversion: BCD digits above, binary below.
    typedef logic [DD_W-1:0] dsf_dd_t;

    // Fields that travel beside the conversion.
    typedef struct packed {
        logic                  ovf;
        logic [NUM_DIGITS-1:0] dots;
        logic                  show;
        logic [2:0]            cnt;
        logic [1:0]            pos;
    } dsf_side_t;

    // Smallest value that no longer fits on a display of the given size (1 to 6).
    function automatic logic [BIN_W-1:0] fit_limit(input logic [2:0] size);
        logic [BIN_W-1:0] lim;
        case (size)
            3'd1:    lim = 20'd10;
            3'd2:    lim = 20'd100;
            3'd3:    lim = 20'd1000;
            3'd4:    lim = 20'd10000;
            3'd5:    lim = 20'd100000;
            default: lim = 20'd1000000;
        endcase
        return lim;
    endfunction

    // Standard seven-segment font, segment A in bit 0.
    function automatic logic [6:0] seg_font(input logic [3:0] d);
        logic [6:0] code;
        case (d)
            4'd0:    code = 7'h3F;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5B;
            4'd3:    code = 7'h4F;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6D;
            4'd6:    code = 7'h7D;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7F;
            4'd9:    code = 7'h6F;
            default: code = 7'h00;
        endcase
        return code;
    endfunction

    // One double-dabble step: correct every BCD digit, then shift left by one.
    function automatic dsf_dd_t dabble_step(input dsf_dd_t s);
        dsf_dd_t t;
        t = s;
        for (int j = 0; j < NUM_DIGITS; j++)
        begin
            if (t[BIN_W + 4*j +: 4] >= 4'd5)
            begin
                t[BIN_W + 4*j +: 4] = t[BIN_W + 4*j +: 4] + 4'd3;
            end
        end
        return {t[DD_W-2:0], 1'b0};
    endfunction

endpackage

>>> design/decimal_to_seven_segment_formatter.sv
// An accepted item moves in order through the pipelined front, four BCD stages,
// encode and serialiser registers. Results leave one per cycle unless m_tready is low;
// an item emitting n digits (1 to 6) holds the serialiser's single output port
// until they have left, and a new item can enter every cycle unless stalled.
// Reset (rst_n, asynchronous, active low) clears all valid bits and sets
// display_size to 4; no memory needs a clearing pass.
module decimal_to_seven_segment_formatter
    import dsf_pkg::*;
#(
    parameter int MAX_DIGITS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,      // display_size
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // value[19:0], dot_mask[27:20], digit_count[30:28],
                                       // start_position[32:31], zero fill
    input  logic        s_tuser,       // show_leading_zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // segments[7:0], digit_address[11:8], zero fill
    output logic        m_tlast,       // last
    output logic        m_tuser        // overflow
);

    localparam int NDAB = 4;

    logic [2:0]                 display_size_reg;
    logic [NDAB:0]              dab_valid;
    logic [NDAB:0]              dab_ready;
    dsf_dd_t                    dab_state [NDAB+1];
    dsf_side_t                  dab_side  [NDAB+1];
    logic                       enc_valid;
    logic                       enc_ready;
    logic [MAX_DIGITS-1:0][7:0] enc_codes;
    dsf_side_t                  enc_side;
    logic [7:0]                 segments;
    logic [3:0]                 digit_address;

    // Display size register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_size_reg <= 3'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            display_size_reg <= cfg_data;
        end
    end

    // Entry stage.
    dsf_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .display_size       (display_size_reg),
        .in_valid           (s_tvalid),
        .in_ready           (s_tready),
        .value              (s_tdata[19:0]),
        .dot_mask           (s_tdata[27:20]),
        .show_leading_zeros (s_tuser),
        .digit_count        (s_tdata[30:28]),
        .start_position     (s_tdata[32:31]),
        .out_valid          (dab_valid[0]),
        .out_ready          (dab_ready[0]),
        .out_state          (dab_state[0]),
        .out_side           (dab_side[0])
    );

    // Binary to BCD conversion stages.
    for (genvar g = 0; g < NDAB; g++)
    begin : g_dab
        dsf_dabble u_dabble (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dab_valid[g]),
            .in_ready  (dab_ready[g]),
            .in_state  (dab_state[g]),
            .in_side   (dab_side[g]),
            .out_valid (dab_valid[g+1]),
            .out_ready (dab_ready[g+1]),
            .out_state (dab_state[g+1]),
            .out_side  (dab_side[g+1])
        );
    end

    // Segment encoding stage.
    dsf_encode #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dab_valid[NDAB]),
        .in_ready  (dab_ready[NDAB]),
        .in_state  (dab_state[NDAB]),
        .in_side   (dab_side[NDAB]),
        .out_valid (enc_valid),
        .out_ready (enc_ready),
        .out_codes (enc_codes),
        .out_side  (enc_side)
    );

    // Output serialiser.
    dsf_serial #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (enc_valid),
        .in_ready     (enc_ready),
        .in_codes     (enc_codes),
        .in_side      (enc_side),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_segments (segments),
        .out_address  (digit_address),
        .out_last     (m_tlast),
        .out_overflow (m_tuser)
    );

    assign m_tdata = {4'h0, digit_address, segments};

endmodule

>>> design/dsf_front.sv
// Entry stage: display size clamp, saturation, count clamp and dot alignment.
module dsf_front
    import dsf_pkg::*;
#(
    parameter int MAX_DIGITS = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [2:0]       display_size,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [BIN_W-1:0] value,
    input  logic [7:0]       dot_mask,
    input  logic             show_leading_zeros,
    input  logic [2:0]       digit_count,
    input  logic [1:0]       start_position,
    output logic             out_valid,
    input  logic             out_ready,
    output dsf_dd_t          out_state,
    output dsf_side_t        out_side
);

    logic             valid_reg;
    dsf_dd_t          state_reg;
    dsf_dd_t          state_next;
    dsf_side_t        side_reg;
    dsf_side_t        side_next;
    logic [2:0]       size_eff;
    logic [BIN_W-1:0] limit;
    logic [7:0]       dot_shift;

    // Effective display size and saturation of values that do not fit.
    always_comb
    begin
        size_eff = display_size;
        if (size_eff == 3'd0)
        begin
            size_eff = 3'd1;
        end
        if (size_eff > 3'(MAX_DIGITS))
        begin
            size_eff = 3'(MAX_DIGITS);
        end
        limit     = fit_limit(size_eff);
        dot_shift = dot_mask >> (4'd8 - {1'b0, size_eff});

        side_next.ovf  = (value >= limit);
        side_next.dots = dot_shift[NUM_DIGITS-1:0];
        side_next.show = show_leading_zeros;
        side_next.cnt  = (digit_count > size_eff) ? size_eff : digit_count;
        side_next.pos  = start_position;
        state_next     = {{BCD_W{1'b0}}, (side_next.ovf ? limit - 20'd1 : value)};
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_side  = side_reg;

endmodule

>>> design/dsf_dabble.sv
// One pipeline stage of the binary to BCD conversion, STEPS_PER_STAGE shift steps deep.
module dsf_dabble
    import dsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dsf_dd_t   in_state,
    input  dsf_side_t in_side,
    output logic      out_valid,
    input  logic      out_ready,
    output dsf_dd_t   out_state,
    output dsf_side_t out_side
);

    logic      valid_reg;
    dsf_dd_t   state_reg;
    dsf_dd_t   state_next;
    dsf_side_t side_reg;

    // Shift steps done by this stage.
    always_comb
    begin
        state_next = in_state;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            state_next = dabble_step(state_next);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            state_reg <= state_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_side  = side_reg;

endmodule

>>> design/dsf_encode.sv
// Segment encoding stage: font lookup, leading-zero blanking and dots.
module dsf_encode
    import dsf_pkg::*;
#(
    parameter int MAX_DIGITS = 6
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dsf_dd_t                       in_state,
    input  dsf_side_t                     in_side,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [MAX_DIGITS-1:0][7:0]    out_codes,
    output dsf_side_t                     out_side
);

    logic                       valid_reg;
    logic [MAX_DIGITS-1:0][7:0] codes_reg;
    logic [MAX_DIGITS-1:0][7:0] codes_next;
    dsf_side_t                  side_reg;
    logic [NUM_DIGITS-1:0]      zero_above;
    logic [BCD_W-1:0]           bcd;

    // Digit j counts from the right; when show is clear, a zero digit is blanked
    // when all digits above it are zero too, unless it is the rightmost one.
    always_comb
    begin
        bcd = in_state[DD_W-1:BIN_W];
        zero_above[NUM_DIGITS-1] = (bcd[4*(NUM_DIGITS-1) +: 4] == 4'd0);
        for (int j = NUM_DIGITS - 2; j >= 0; j--)
        begin
            zero_above[j] = zero_above[j+1] && (bcd[4*j +: 4] == 4'd0);
        end
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            if (!in_side.show && (j != 0) && zero_above[j])
            begin
                codes_next[j][6:0] = 7'h00;
            end
            else
            begin
                codes_next[j][6:0] = seg_font(bcd[4*j +: 4]);
            end
            codes_next[j][7] = in_side.dots[j];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            codes_reg <= codes_next;
            side_reg  <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_codes = codes_reg;
    assign out_side  = side_reg;

endmodule

>>> design/dsf_serial.sv
// Output serialiser: emits the selected digits of one item, one per cycle while out_ready is high.
`include "decimal_to_seven_segment_formatter_assert.svh"
module dsf_serial
    import dsf_pkg::*;
#(
    parameter int MAX_DIGITS = 6
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [MAX_DIGITS-1:0][7:0] in_codes,
    input  dsf_side_t                  in_side,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_segments,
    output logic [3:0]                 out_address,
    output logic                       out_last,
    output logic                       out_overflow
);

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic                       busy_reg;
    logic [MAX_DIGITS-1:0][7:0] codes_reg;
    logic [IW-1:0]              rem_reg;
    logic [3:0]                 addr_reg;
    logic                       ovf_reg;
    logic                       out_fire;
    logic                       load;

    // A new item is taken when idle or while the final digit is taken.
    assign out_fire = busy_reg && out_ready;
    assign in_ready = !busy_reg || (out_ready && (rem_reg == '0));
    assign load     = in_valid && in_ready;

    // Busy flag; an item that selects no digit is dropped on entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (load)
        begin
            busy_reg <= (in_side.cnt != 3'd0);
        end
        else if (out_fire && (rem_reg == '0))
        begin
            busy_reg <= 1'b0;
        end
    end

    // Digit store, remaining count and address counter.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            codes_reg <= in_codes;
            rem_reg   <= IW'(in_side.cnt - 3'd1);
            addr_reg  <= {2'b00, in_side.pos};
            ovf_reg   <= in_side.ovf;
        end
        else if (out_fire)
        begin
            rem_reg  <= rem_reg - IW'(1);
            addr_reg <= addr_reg + 4'd1;
        end
    end

    assign out_valid    = busy_reg;
    assign out_segments = codes_reg[rem_reg];
    assign out_address  = addr_reg;
    assign out_last     = (rem_reg == '0);
    assign out_overflow = ovf_reg;

    `DSF_ASSERT_RST(a_last_frees_input, (out_fire && out_last) |-> in_ready, "input not ready after final digit")
    `DSF_ASSERT_RST(a_addr_steps, (out_fire && !out_last) |=> (addr_reg == 4'($past(addr_reg) + 4'd1)), "digit address did not advance")
    `DSF_ASSERT_RST(a_rem_in_range, busy_reg |-> (rem_reg <= IW'(MAX_DIGITS - 1)), "remaining digit count out of range")
    `DSF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result offered during reset")

endmodule
